### src/clit_pkg.sv
`default_nettype none

package clit_pkg;

   // table geometry
   localparam int MAX_POINTS = 64;
   localparam int NUM_BINS   = 16;
   localparam int IDX_W      = 6;
   localparam int BIN_W      = 4;
   localparam int NPTS_W     = 7;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int VADDR_W    = IDX_W + BIN_W;
   localparam int PROD_W     = 2 * VAL_W;

   // divider step count: the quotient always fits in one value word
   localparam int DIV_STEPS  = VAL_W;
   localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

   // request word layout
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

   // action codes carried on req_tuser
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KFIRST,
      ST_CFIRST,
      ST_CLAST,
      ST_SRCH,
      ST_VEND,
      ST_VEND_RD,
      ST_VLO,
      ST_VHI,
      ST_VDIFF,
      ST_MUL,
      ST_DIVS,
      ST_DIVW,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### src/clit_table.sv
`default_nettype none

// Breakpoint key and value storage, one write port and one registered read port each
module clit_table (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [clit_pkg::IDX_W-1:0]    wr_idx,
   input  wire logic [clit_pkg::BIN_W-1:0]    wr_bin,
   input  wire logic [clit_pkg::KEY_W-1:0]    wr_key,
   input  wire logic [clit_pkg::VAL_W-1:0]    wr_val,
   input  wire logic [clit_pkg::IDX_W-1:0]    key_rd_addr,
   output logic      [clit_pkg::KEY_W-1:0]    key_rd_data,
   input  wire logic [clit_pkg::VADDR_W-1:0]  val_rd_addr,
   output logic      [clit_pkg::VAL_W-1:0]    val_rd_data
);

   logic [clit_pkg::KEY_W-1:0] key_mem [2**clit_pkg::IDX_W];
   logic [clit_pkg::VAL_W-1:0] val_mem [2**clit_pkg::VADDR_W];

   // key column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx] <= wr_key;
      end
      key_rd_data <= key_mem[key_rd_addr];
   end

   // value array, row = point, column = bin
   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[{wr_idx, wr_bin}] <= wr_val;
      end
      val_rd_data <= val_mem[val_rd_addr];
   end

endmodule

`default_nettype wire

### src/clit_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Expects dividend[63:32] < divisor so the quotient fits in 32 bits.
module clit_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [clit_pkg::PROD_W-1:0]    dividend,
   input  wire logic [clit_pkg::VAL_W-1:0]     divisor,
   output logic                                done,
   output logic      [clit_pkg::VAL_W-1:0]     quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [clit_pkg::DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [clit_pkg::VAL_W-1:0]    rem_ff, rem_in;
   logic [clit_pkg::VAL_W-1:0]    low_ff, low_in;
   logic [clit_pkg::VAL_W-1:0]    div_ff, div_in;
   logic [clit_pkg::VAL_W:0]      trial;
   logic [clit_pkg::VAL_W:0]      diff;
   logic                          ge;

   // one shift-and-subtract step
   always_comb begin
      trial = {rem_ff, low_ff[clit_pkg::VAL_W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = clit_pkg::DCNT_W'(clit_pkg::DIV_STEPS);
         rem_in  = dividend[clit_pkg::PROD_W-1:clit_pkg::VAL_W];
         low_in  = dividend[clit_pkg::VAL_W-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[clit_pkg::VAL_W-1:0] : trial[clit_pkg::VAL_W-1:0];
         low_in = {low_ff[clit_pkg::VAL_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == clit_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

`default_nettype wire

### src/clamped_linear_interp_table.sv
// Clamped piecewise-linear lookup table, 64 breakpoints by 16 bins.
// req channel: one word per item. req_tuser selects a table write or a query.
// A write stores the point's key and that bin's value together and gives
// no response. A query gives one rsp word: the Q16.16 value, plus clamped and
// table_empty flags on rsp_tuser.
// csr channel: writes the breakpoint count (above 64 saturates to 64); it is
// always ready. The user must see that it is written only while no query is
// in flight; the block has no check for this. Writes are taken every cycle. A
// query holds req_tready low while a small sequencer reads the first and last
// keys. A key at or below the first point or at or above the last then reads
// that point's value. Otherwise the sequencer walks the key memory one entry
// per cycle up to the upper point of the bracket, reads the two bracketing
// values, multiplies once and runs a restoring divider. An empty table skips
// all this. req_tready is back in the cycle after the response is loaded.
// The response sits in an output register; the next item is accepted while it
// waits. If rsp_tready stays low, a finished query holds until the register
// frees up, and the req side stalls behind it.
// Reset clears the count, the sequencer and rsp_tvalid; the table contents
// are not cleared and must be written before being queried.
`default_nettype none

module clamped_linear_interp_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // csr: num_points
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [clit_pkg::NPTS_W-1:0]       csr_data,
   // req_tdata, lsb up: point_index[5:0], point_key[31:0], point_value[31:0],
   //   bin[3:0], query_key[31:0], zero pad[5:0]
   // req_tuser: action
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [clit_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [0:0]                        req_tuser,
   // rsp_tdata: result_value[31:0]
   // rsp_tuser, lsb up: clamped, table_empty
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [clit_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic      [1:0]                        rsp_tuser
);

   // request word fields
   logic [clit_pkg::IDX_W-1:0]   req_point_index;
   logic [clit_pkg::KEY_W-1:0]   req_point_key;
   logic [clit_pkg::VAL_W-1:0]   req_point_value;
   logic [clit_pkg::BIN_W-1:0]   req_bin;
   logic [clit_pkg::KEY_W-1:0]   req_query_key;
   logic                         req_accept;
   logic                         rsp_free;

   assign req_point_index = req_tdata[5:0];
   assign req_point_key   = req_tdata[37:6];
   assign req_point_value = req_tdata[69:38];
   assign req_bin         = req_tdata[73:70];
   assign req_query_key   = req_tdata[105:74];
   assign req_accept      = req_tvalid & req_tready;

   // state and datapath registers
   clit_pkg::state_type             state_ff, state_in;
   logic [clit_pkg::NPTS_W-1:0]     npts_ff, npts_in;
   logic [clit_pkg::BIN_W-1:0]      bin_ff, bin_in;
   logic [clit_pkg::KEY_W-1:0]      qkey_ff, qkey_in;
   logic [clit_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [clit_pkg::KEY_W-1:0]      prev_ff, prev_in;
   logic [clit_pkg::KEY_W-1:0]      dx_ff, dx_in;
   logic [clit_pkg::KEY_W-1:0]      den_ff, den_in;
   logic [clit_pkg::VAL_W-1:0]      v0_ff, v0_in;
   logic                            sign_ff, sign_in;
   logic [clit_pkg::VAL_W-1:0]      mag_ff, mag_in;
   logic [clit_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [clit_pkg::VAL_W-1:0]      res_ff, res_in;
   logic                            clamped_ff, clamped_in;
   logic                            empty_ff, empty_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [clit_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                      rsp_tuser_ff, rsp_tuser_in;

   // sequencer outputs
   logic                            tbl_wr_en;
   logic [clit_pkg::IDX_W-1:0]      key_addr;
   logic [clit_pkg::VADDR_W-1:0]    val_addr;
   logic                            div_start;
   logic                            rsp_load;

   // table and divider results
   logic [clit_pkg::KEY_W-1:0]      key_data;
   logic [clit_pkg::VAL_W-1:0]      val_data;
   logic                            div_done;
   logic [clit_pkg::VAL_W-1:0]      div_quo;

   logic [clit_pkg::IDX_W-1:0]      last_idx;
   logic [clit_pkg::VAL_W:0]        vdiff;
   logic [clit_pkg::VAL_W:0]        vdiff_neg;

   assign rsp_free  = ~rsp_tvalid_ff | rsp_tready;
   assign last_idx  = clit_pkg::IDX_W'(npts_ff - 1'b1);
   assign vdiff     = {val_data[clit_pkg::VAL_W-1], val_data}
                    - {v0_ff[clit_pkg::VAL_W-1], v0_ff};
   assign vdiff_neg = '0 - vdiff;

   clit_table u_table (
      .clock       (clock),
      .wr_en       (tbl_wr_en),
      .wr_idx      (req_point_index),
      .wr_bin      (req_bin),
      .wr_key      (req_point_key),
      .wr_val      (req_point_value),
      .key_rd_addr (key_addr),
      .key_rd_data (key_data),
      .val_rd_addr (val_addr),
      .val_rd_data (val_data)
   );

   clit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         clit_pkg::ST_IDLE: begin
            if (req_accept && req_tuser[0] == clit_pkg::ACT_QUERY) begin
               state_in = (npts_ff == '0) ? clit_pkg::ST_DONE : clit_pkg::ST_KFIRST;
            end
         end
         clit_pkg::ST_KFIRST: state_in = clit_pkg::ST_CFIRST;
         clit_pkg::ST_CFIRST: begin
            state_in = (qkey_ff <= key_data) ? clit_pkg::ST_VEND : clit_pkg::ST_CLAST;
         end
         clit_pkg::ST_CLAST: begin
            state_in = (qkey_ff >= key_data) ? clit_pkg::ST_VEND : clit_pkg::ST_SRCH;
         end
         clit_pkg::ST_SRCH: begin
            if (key_data > qkey_ff || idx_ff == last_idx) begin
               state_in = clit_pkg::ST_VLO;
            end
         end
         clit_pkg::ST_VEND:    state_in = clit_pkg::ST_VEND_RD;
         clit_pkg::ST_VEND_RD: state_in = clit_pkg::ST_DONE;
         clit_pkg::ST_VLO:     state_in = clit_pkg::ST_VHI;
         clit_pkg::ST_VHI:     state_in = clit_pkg::ST_VDIFF;
         clit_pkg::ST_VDIFF:   state_in = clit_pkg::ST_MUL;
         clit_pkg::ST_MUL:     state_in = clit_pkg::ST_DIVS;
         clit_pkg::ST_DIVS:    state_in = clit_pkg::ST_DIVW;
         clit_pkg::ST_DIVW: begin
            if (div_done) begin
               state_in = clit_pkg::ST_DONE;
            end
         end
         clit_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = clit_pkg::ST_IDLE;
            end
         end
         default: state_in = clit_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: memory addresses and strobes
   always_comb begin
      req_tready = 1'b0;
      tbl_wr_en  = 1'b0;
      key_addr   = '0;
      val_addr   = '0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         clit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            tbl_wr_en  = req_accept & (req_tuser[0] == clit_pkg::ACT_WRITE);
         end
         clit_pkg::ST_CFIRST: key_addr = last_idx;
         clit_pkg::ST_CLAST:  key_addr = clit_pkg::IDX_W'(1);
         clit_pkg::ST_SRCH:   key_addr = idx_ff + 1'b1;
         clit_pkg::ST_VEND:   val_addr = {idx_ff, bin_ff};
         clit_pkg::ST_VLO:    val_addr = {idx_ff - 1'b1, bin_ff};
         clit_pkg::ST_VHI:    val_addr = {idx_ff, bin_ff};
         clit_pkg::ST_DIVS:   div_start = 1'b1;
         clit_pkg::ST_DONE:   rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      npts_in    = npts_ff;
      bin_in     = bin_ff;
      qkey_in    = qkey_ff;
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      dx_in      = dx_ff;
      den_in     = den_ff;
      v0_in      = v0_ff;
      sign_in    = sign_ff;
      mag_in     = mag_ff;
      prod_in    = prod_ff;
      res_in     = res_ff;
      clamped_in = clamped_ff;
      empty_in   = empty_ff;

      // count write, saturating at the table size
      if (csr_valid && csr_ready) begin
         if (csr_data > clit_pkg::NPTS_W'(clit_pkg::MAX_POINTS)) begin
            npts_in = clit_pkg::NPTS_W'(clit_pkg::MAX_POINTS);
         end else begin
            npts_in = csr_data;
         end
      end

      case (state_ff)
         clit_pkg::ST_IDLE: begin
            if (req_accept) begin
               bin_in     = req_bin;
               qkey_in    = req_query_key;
               clamped_in = 1'b0;
               empty_in   = (npts_ff == '0);
               res_in     = '0;
            end
         end
         clit_pkg::ST_CFIRST: begin
            // below or at the first key
            prev_in    = key_data;
            idx_in     = '0;
            clamped_in = (qkey_ff < key_data);
         end
         clit_pkg::ST_CLAST: begin
            // at or above the last key, else start the search at point 1
            if (qkey_ff >= key_data) begin
               idx_in     = last_idx;
               clamped_in = (qkey_ff > key_data);
            end else begin
               idx_in = clit_pkg::IDX_W'(1);
            end
         end
         clit_pkg::ST_SRCH: begin
            if (key_data > qkey_ff || idx_ff == last_idx) begin
               dx_in  = qkey_ff - prev_ff;
               den_in = key_data - prev_ff;
            end else begin
               prev_in = key_data;
               idx_in  = idx_ff + 1'b1;
            end
         end
         clit_pkg::ST_VEND_RD: res_in = val_data;
         clit_pkg::ST_VHI:     v0_in = val_data;
         clit_pkg::ST_VDIFF: begin
            sign_in = vdiff[clit_pkg::VAL_W];
            mag_in  = vdiff[clit_pkg::VAL_W] ? vdiff_neg[clit_pkg::VAL_W-1:0]
                                             : vdiff[clit_pkg::VAL_W-1:0];
         end
         clit_pkg::ST_MUL: begin
            prod_in = clit_pkg::PROD_W'(mag_ff) * clit_pkg::PROD_W'(dx_ff);
         end
         clit_pkg::ST_DIVW: begin
            if (div_done) begin
               res_in = sign_ff ? (v0_ff - div_quo) : (v0_ff + div_quo);
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tuser_in = rsp_tuser_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = res_ff;
         rsp_tuser_in  = {empty_ff, clamped_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= clit_pkg::ST_IDLE;
         npts_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         npts_ff       <= npts_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      qkey_ff      <= qkey_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      dx_ff        <= dx_in;
      den_ff       <= den_in;
      v0_ff        <= v0_in;
      sign_ff      <= sign_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      clamped_ff   <= clamped_in;
      empty_ff     <= empty_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

### tb/clamped_linear_interp_table_tb.sv
module clamped_linear_interp_table_tb;
   import clit_pkg::*;

   localparam int RANDOM_OPS    = 1600;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int NUM_DIRECTED  = 25;

   // one request word, split into its fields
   typedef struct {
      logic             action;
      logic [IDX_W-1:0] pidx;
      logic [KEY_W-1:0] pkey;
      logic [VAL_W-1:0] pval;
      logic [BIN_W-1:0] bin;
      logic [KEY_W-1:0] qkey;
   } table_op_type;

   // one response word
   typedef struct {
      logic [VAL_W-1:0] value;
      logic             clamped;
      logic             empty;
   } lookup_result_type;

   typedef enum logic {ROW_SET_COUNT, ROW_ITEM} row_kind_type;

   // directed stimulus row; given marks a hand-written expected response
   typedef struct {
      row_kind_type      kind;
      logic [NPTS_W-1:0] count;
      table_op_type      op;
      bit                given;
      lookup_result_type result;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [NPTS_W-1:0]     csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // shadow copy of the table and of the point count
   logic [KEY_W-1:0] tbl_key [MAX_POINTS];
   logic [VAL_W-1:0] tbl_val [MAX_POINTS][NUM_BINS];
   bit               key_set [MAX_POINTS];
   bit               val_set [MAX_POINTS][NUM_BINS];
   int               pts_in_use = 0;

   lookup_result_type lookup_q [$];
   directed_row_type  directed_rows [NUM_DIRECTED];
   int                burst_left = 0;
   int                ops_sent = 0;
   int                mismatch_count = 0;
   longint            cycle_count = 0;

   clamped_linear_interp_table dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // expected response of a query against the shadow table
   function automatic lookup_result_type predict_lookup(logic [BIN_W-1:0] bin,
                                                        logic [KEY_W-1:0] qkey);
      lookup_result_type res;
      int             last;
      int             i;
      logic [KEY_W-1:0] k0, k1, dx, den;
      logic [VAL_W-1:0] v0, v1;
      longint         diff;
      logic [63:0]    mag, q;
      res = '{'0, 1'b0, 1'b0};
      if (pts_in_use == 0) begin
         res.empty = 1'b1;
         return res;
      end
      last = pts_in_use - 1;
      if (qkey <= tbl_key[0]) begin
         res.clamped = (qkey < tbl_key[0]);
         res.value   = tbl_val[0][bin];
         return res;
      end
      if (qkey >= tbl_key[last]) begin
         res.clamped = (qkey > tbl_key[last]);
         res.value   = tbl_val[last][bin];
         return res;
      end
      // first point past the key closes the bracket, even on unsorted keys
      i = 1;
      while (i < last && tbl_key[i] <= qkey) i++;
      k0 = tbl_key[i-1];
      k1 = tbl_key[i];
      v0 = tbl_val[i-1][bin];
      v1 = tbl_val[i][bin];
      diff = longint'($signed(v1)) - longint'($signed(v0));
      mag  = (diff < 0) ? -diff : diff;
      dx   = qkey - k0;
      den  = k1 - k0;
      if (den == 0) den = 1;
      q = (mag * {32'd0, dx}) / {32'd0, den};
      res.value = (diff < 0) ? v0 - q[31:0] : v0 + q[31:0];
      return res;
   endfunction

   // a query may only touch points and values that were written
   function automatic bit column_ready(logic [BIN_W-1:0] bin);
      for (int p = 0; p < pts_in_use; p++)
         if (!key_set[p] || !val_set[p][bin]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic table_op_type write_op(logic [IDX_W-1:0] pidx,
                                             logic [KEY_W-1:0] pkey,
                                             logic [VAL_W-1:0] pval,
                                             logic [BIN_W-1:0] bin);
      return '{ACT_WRITE, pidx, pkey, pval, bin, $urandom};
   endfunction

   function automatic table_op_type query_op(logic [BIN_W-1:0] bin, logic [KEY_W-1:0] qkey);
      return '{ACT_QUERY, IDX_W'($urandom), $urandom, $urandom, bin, qkey};
   endfunction

   // directed table rows
   function automatic directed_row_type count_row(logic [NPTS_W-1:0] n);
      return '{ROW_SET_COUNT, n, write_op('0, '0, '0, '0), 1'b0, '{'0, 1'b0, 1'b0}};
   endfunction

   function automatic directed_row_type write_row(logic [IDX_W-1:0] pidx,
                                                  logic [KEY_W-1:0] pkey,
                                                  logic [VAL_W-1:0] pval,
                                                  logic [BIN_W-1:0] bin);
      return '{ROW_ITEM, '0, write_op(pidx, pkey, pval, bin), 1'b0, '{'0, 1'b0, 1'b0}};
   endfunction

   function automatic directed_row_type query_row(logic [BIN_W-1:0] bin,
                                                  logic [KEY_W-1:0] qkey);
      return '{ROW_ITEM, '0, query_op(bin, qkey), 1'b0, '{'0, 1'b0, 1'b0}};
   endfunction

   function automatic directed_row_type check_row(logic [BIN_W-1:0] bin,
                                                  logic [KEY_W-1:0] qkey,
                                                  logic [VAL_W-1:0] value, logic clamped,
                                                  logic empty);
      return '{ROW_ITEM, '0, query_op(bin, qkey), 1'b1, '{value, clamped, empty}};
   endfunction

   // drive one request word in bursts with random gaps, then track it
   task automatic send_op(table_op_type op, bit given, lookup_result_type result);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op.action;
      req_tdata  <= {6'd0, op.qkey, op.bin, op.pval, op.pkey, op.pidx};
      do @(posedge clock); while (!req_tready);
      ops_sent++;
      // index and bin widths keep every write in range
      if (op.action == ACT_WRITE) begin
         tbl_key[op.pidx]         = op.pkey;
         tbl_val[op.pidx][op.bin] = op.pval;
         key_set[op.pidx]         = 1'b1;
         val_set[op.pidx][op.bin] = 1'b1;
      end else begin
         lookup_q.push_back(given ? result : predict_lookup(op.bin, op.qkey));
      end
   endtask

   // stop sending, let every response drain and the sequencer go idle
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(logic [NPTS_W-1:0] count);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      pts_in_use = (count > MAX_POINTS) ? MAX_POINTS : count;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // new count, fresh breakpoints for a few columns, then a run of lookups and stray writes
   task automatic run_random_phase();
      logic [NPTS_W-1:0] count;
      logic [KEY_W-1:0]  phase_key [MAX_POINTS];
      logic [BIN_W-1:0]  cols [3];
      logic [BIN_W-1:0]  b;
      logic [KEY_W-1:0]  span, k, lo, hi;
      lookup_result_type no_result;
      int                n, ncols, nops, j, r;
      bit                ordered;
      no_result = '{'0, 1'b0, 1'b0};
      case ($urandom_range(0, 9))
         0: count = 7'd0;
         1: count = 7'd1;
         2: count = 7'd2;
         3: count = 7'd64;
         4: count = NPTS_W'($urandom_range(65, 127));
         default: count = NPTS_W'($urandom_range(3, 12));
      endcase
      quiesce();
      set_point_count(count);
      n = pts_in_use;

      // keys mostly ascending with some repeats; now and then fully shuffled
      ordered = ($urandom_range(0, 4) != 0);
      span = 32'hFFFF_FFFF / (n + 1);
      if ($urandom_range(0, 3) == 0) span = $urandom_range(1, 1000);
      k = $urandom_range(0, span);
      for (int p = 0; p < n; p++) begin
         if (!ordered) k = $urandom;
         else if (p > 0 && $urandom_range(0, 7) != 0) k = k + $urandom_range(1, span);
         phase_key[p] = k;
      end

      // fill whole value columns
      ncols = (n == 0) ? 0 : (n > 16) ? 1 : $urandom_range(1, 3);
      for (int c = 0; c < ncols; c++) begin
         cols[c] = BIN_W'($urandom);
         for (int p = 0; p < n; p++)
            send_op(write_op(IDX_W'(p), phase_key[p], rand_value(), cols[c]), 1'b0, no_result);
      end

      nops = $urandom_range(15, 40);
      repeat (nops) begin
         if ($urandom_range(0, 9) == 0) begin
            // stray write: new value at a live point, or anything past the end
            j = $urandom_range(0, MAX_POINTS - 1);
            send_op(write_op(IDX_W'(j), (j < n) ? phase_key[j] : $urandom, rand_value(),
                             BIN_W'($urandom)), 1'b0, no_result);
         end else begin
            b = (ncols > 0 && $urandom_range(0, 9) != 0) ? cols[$urandom_range(0, ncols - 1)]
                                                          : BIN_W'($urandom);
            if (!column_ready(b)) b = cols[0];
            k = $urandom;
            r = $urandom_range(0, 19);
            if (n > 0) begin
               if (r < 10) begin
                  // inside one bracket
                  j  = (n > 1) ? $urandom_range(0, n - 2) : 0;
                  lo = phase_key[j];
                  hi = (n > 1) ? phase_key[j+1] : lo;
                  k  = (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
               end else if (r < 13) begin
                  k = phase_key[$urandom_range(0, n - 1)];
               end else if (r == 13) begin
                  k = '0;
               end else if (r == 14) begin
                  k = '1;
               end else if (r < 17) begin
                  if (phase_key[0] != 0) k = $urandom_range(0, phase_key[0] - 1);
               end else if (r < 19) begin
                  if (phase_key[n-1] != '1)
                     k = $urandom_range(phase_key[n-1] + 1, 32'hFFFF_FFFF);
               end
            end
            send_op(query_op(b, k), 1'b0, no_result);
         end
      end
   endtask

   // response checker
   always @(posedge clock) begin
      lookup_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
         if (lookup_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: response word with no query pending, value=%h flags=%b",
                        rsp_tdata, rsp_tuser);
         end else begin
            want = lookup_q.pop_front();
            if (got.value !== want.value || got.clamped !== want.clamped ||
                got.empty !== want.empty) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected value=%h clamped=%b empty=%b, ",
                            "got value=%h clamped=%b empty=%b"},
                           want.value, want.clamped, want.empty,
                           got.value, got.clamped, got.empty);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("clamped_linear_interp_table_tb failed");
         $finish;
      end
   end

   // receiver stall pattern: long ready stretches, short stalls, rare long stalls
   initial begin
      int hold;
      int pick;
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(1, 40);
            end else if (pick < 9) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(1, 4);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(20, 150);
            end
         end
      end
   end

   initial begin
      int random_start;
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;

      directed_rows = '{
         // empty table
         count_row(7'd0),
         check_row(4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1),
         check_row(4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1),
         // single point: exact hit, then both sides
         count_row(7'd1),
         write_row(6'd0, 32'h1000_0000, 32'h0005_0000, 4'd0),
         check_row(4'd0, 32'h1000_0000, 32'h0005_0000, 1'b0, 1'b0),
         check_row(4'd0, 32'h0000_0000, 32'h0005_0000, 1'b1, 1'b0),
         check_row(4'd0, 32'hFFFF_FFFF, 32'h0005_0000, 1'b1, 1'b0),
         // two points over the full key range, value extremes
         count_row(7'd2),
         write_row(6'd0, 32'h0000_0000, 32'h8000_0000, 4'd15),
         write_row(6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 4'd15),
         check_row(4'd15, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0),
         check_row(4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0),
         query_row(4'd15, 32'h8000_0000),
         query_row(4'd15, 32'h0000_0001),
         query_row(4'd15, 32'hFFFF_FFFE),
         // falling slope: exact midpoint, truncation, clamps on both ends
         write_row(6'd0, 32'h0200_0000, 32'h0001_0000, 4'd0),
         write_row(6'd1, 32'h0400_0000, 32'hFFFF_0000, 4'd0),
         check_row(4'd0, 32'h0300_0000, 32'h0000_0000, 1'b0, 1'b0),
         query_row(4'd0, 32'h0200_0001),
         check_row(4'd0, 32'h0100_0000, 32'h0001_0000, 1'b1, 1'b0),
         check_row(4'd0, 32'h0500_0000, 32'hFFFF_0000, 1'b1, 1'b0),
         // keys out of order
         write_row(6'd1, 32'h0100_0000, 32'h0003_0000, 4'd0),
         check_row(4'd0, 32'h0180_0000, 32'h0001_0000, 1'b1, 1'b0),
         check_row(4'd0, 32'h0300_0000, 32'h0003_0000, 1'b1, 1'b0)
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SET_COUNT) begin
            quiesce();
            set_point_count(directed_rows[i].count);
         end else begin
            send_op(directed_rows[i].op, directed_rows[i].given, directed_rows[i].result);
         end
      end

      random_start = ops_sent;
      while (ops_sent - random_start < RANDOM_OPS) run_random_phase();

      quiesce();
      if (mismatch_count == 0 && lookup_q.size() == 0)
         $display("clamped_linear_interp_table_tb passed");
      else
         $display("clamped_linear_interp_table_tb failed");
      $finish;
   end

endmodule

### files.f
src/clit_pkg.sv
src/clit_table.sv
src/clit_div.sv
src/clamped_linear_interp_table.sv
tb/clamped_linear_interp_table_tb.sv
